@@ hdl/kdsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key debounce package
// Shared constants, key step codes and item types for the key debounce block.
// ----------------------------------------------------------------------------
package kdsl_pkg;

	localparam int NUM_KEYS = 4;
	localparam int CNT_W = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] LONG_TICKS_RESET = CNT_W'(70);

	typedef enum logic [1:0] {
		STEP_IDLE    = 2'd0,
		STEP_CONFIRM = 2'd1,
		STEP_PRESSED = 2'd2
	} step_t;

	typedef struct packed {
		logic [NUM_KEYS-1:0] key_levels;
		logic [NUM_KEYS-1:0] clear_short;
		logic [NUM_KEYS-1:0] clear_long;
	} in_item_t;

	typedef struct packed {
		logic [NUM_KEYS-1:0] short_flags;
		logic [NUM_KEYS-1:0] long_flags;
	} out_item_t;

	typedef struct packed {
		logic set_short;
		logic set_long;
	} key_set_t;

endpackage

@@ hdl/kdsl_key.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key step machine
// Per-key idle/confirm/pressed machine with saturating hold count; reports
// short and long press set requests for the current tick.
// ----------------------------------------------------------------------------
module kdsl_key
	import kdsl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             low,
	input  logic [CNT_W-1:0] long_ticks,
	output key_set_t         set
);

	step_t            step_q;
	step_t            step_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_inc;

	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + CNT_W'(1);

	always_comb begin
		step_d        = step_q;
		count_d       = count_q;
		set.set_short = 1'b0;
		set.set_long  = 1'b0;
		case (step_q)
			STEP_CONFIRM: begin
				step_d = low ? STEP_PRESSED : STEP_IDLE;
			end
			STEP_PRESSED: begin
				if (!low) begin
					step_d        = STEP_IDLE;
					set.set_short = (count_q < long_ticks);
				end else begin
					count_d      = count_inc;
					set.set_long = (count_inc > long_ticks);
				end
			end
			default: begin
				if (low) begin
					step_d  = STEP_CONFIRM;
					count_d = '0;
				end else begin
					step_d = STEP_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_IDLE;
			count_q <= '0;
		end else if (en) begin
			step_q  <= step_d;
			count_q <= count_d;
		end
	end

endmodule

@@ hdl/key_debounce_short_long_press_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key debounce with short and long press detection
// One scan tick per item; updates every key machine and the sticky flags.
// ----------------------------------------------------------------------------
// Result: out_valid rises in the cycle after an item is accepted.
// Throughput: one item per cycle while out_ready is high or none is held;
//   the flags are the result register: a new item enters as the last drains.
// Reset: all key machines idle, hold counts and flags zero, threshold 70;
//   no clearing pass.
module key_debounce_short_long_press_top
	import kdsl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	logic                in_fire;
	logic                out_valid_q;
	logic [CNT_W-1:0]    long_ticks_q;
	logic [NUM_KEYS-1:0] short_q;
	logic [NUM_KEYS-1:0] long_q;
	logic [NUM_KEYS-1:0] set_short;
	logic [NUM_KEYS-1:0] set_long;
	key_set_t            key_set [NUM_KEYS];

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		kdsl_key u_key (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (in_fire),
			.low        (!in_data.key_levels[k]),
			.long_ticks (long_ticks_q),
			.set        (key_set[k])
		);
		assign set_short[k] = key_set[k].set_short;
		assign set_long[k]  = key_set[k].set_long;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= LONG_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			long_ticks_q <= cfg_data;
		end
	end

	// clear before set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			short_q     <= '0;
			long_q      <= '0;
		end else begin
			if (in_fire) begin
				short_q <= (short_q & ~in_data.clear_short) | set_short;
				long_q  <= (long_q & ~in_data.clear_long) | set_long;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid            = out_valid_q;
	assign out_data.short_flags = short_q;
	assign out_data.long_flags  = long_q;

	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid)
		else $error("item accepted without result");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> ($stable(short_q) && $stable(long_q)))
		else $error("flags changed without item");

	a_short_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> ((short_q & ~$past(short_q) & ~$past(in_data.key_levels)) == '0))
		else $error("short flag set while key low");

endmodule
